FILE: sv/bac_pkg.sv
package bac_pkg;

	localparam int PLANES           = 32;
	localparam int SHIFT_W          = 5;
	localparam int THR_W            = 17;
	localparam int Q_FRAC           = 16;
	localparam int TOTAL_W          = 6;
	localparam int DATA_W           = 32;
	localparam int ADDR_W           = 3;
	localparam int MAX_ELEMENTS_DEF = 256;

	localparam logic [THR_W-1:0] ONE_Q16 = THR_W'(65536);

	// register index, taken from paddr[2]
	localparam logic [0:0] REG_MASK_SHIFT = 1'b0;
	localparam logic [0:0] REG_THRESHOLD  = 1'b1;

	function automatic logic [PLANES-1:0] start_mask(input logic [SHIFT_W-1:0] shift);
		start_mask = {PLANES{1'b1}} >> shift;
	endfunction

	// adder tree: 32 -> 16 x 2b -> 8 x 3b -> 4 x 4b -> 2 x 5b -> 6b
	function automatic logic [TOTAL_W-1:0] ones_in(input logic [PLANES-1:0] v);
		logic [1:0] l1 [16];
		logic [2:0] l2 [8];
		logic [3:0] l3 [4];
		logic [4:0] l4 [2];
		for (int i = 0; i < 16; i++) begin
			l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
		end
		for (int i = 0; i < 8; i++) begin
			l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		end
		for (int i = 0; i < 4; i++) begin
			l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
		end
		ones_in = {1'b0, l4[0]} + {1'b0, l4[1]};
	endfunction

endpackage

FILE: sv/bitplane_agreement_counter.sv
// Bit-plane agreement counter.
// Item channel (item_valid/item_ready): one pair of 32-bit words per item,
// word_a and word_b, plus last_element marking the final pair of a
// neighbourhood. Result channel (result_valid/result_ready): one item per
// neighbourhood, issued for the last pair only: the all-agree mask, its
// popcount, the mask of planes whose agreement count reaches
// floor(threshold_fraction * elements / 65536), and an overflow flag set when
// more than MAX_ELEMENTS pairs arrived (counts saturate there).
// Throughput: one pair per cycle while item_ready is high; the 32 plane
// counters, the mask and the element count all update in parallel.
// After the last pair is taken, its result passes the input register, the
// accumulate/snapshot stage and the threshold stage into the result register.
// A stalled receiver holds the result; the snapshot stage behind it gives one
// further slot, and item_ready only drops when a last pair cannot move on.
// Non-last pairs keep flowing during a stall.
// Reset clears the counters and flags, sets mask_shift to 0 and the threshold
// to 1.0. APB port: mask_shift at 0x0, threshold_fraction at 0x4.
module bitplane_agreement_counter #(
	parameter int MAX_ELEMENTS = bac_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bac_pkg::ADDR_W-1:0]    paddr,
	input  logic [bac_pkg::DATA_W-1:0]    pwdata,
	output logic [bac_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	// item channel
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [31:0]                   word_a,
	input  logic [31:0]                   word_b,
	input  logic                          last_element,
	// result channel
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [31:0]                   all_agree_mask,
	output logic [5:0]                    agree_bit_total,
	output logic [31:0]                   plane_pass_mask,
	output logic                          count_overflow
);

	localparam int PLANES = bac_pkg::PLANES;
	localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
	localparam int PROD_W = bac_pkg::THR_W + CNT_W;
	localparam int NEED_W = PROD_W - bac_pkg::Q_FRAC;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);

	// configuration registers
	logic [bac_pkg::SHIFT_W-1:0] mask_shift_q;
	logic [bac_pkg::THR_W-1:0]   threshold_q;
	logic                        cfg_wr;
	logic [0:0]                  reg_idx;

	// input register
	logic              valid_s1;
	logic [31:0]       word_a_s1;
	logic [31:0]       word_b_s1;
	logic              last_s1;

	// neighbourhood state
	logic [PLANES-1:0] acc_q;
	logic [CNT_W-1:0]  cnt_q [PLANES];
	logic [CNT_W-1:0]  total_q;
	logic              ovf_q;

	// snapshot of the finished neighbourhood
	logic              valid_s2;
	logic [PLANES-1:0] acc_s2;
	logic [CNT_W-1:0]  cnt_s2 [PLANES];
	logic [CNT_W-1:0]  total_s2;
	logic              ovf_s2;

	// result register
	logic                         result_valid_q;
	logic [PLANES-1:0]            mask_q;
	logic [bac_pkg::TOTAL_W-1:0]  ones_q;
	logic [PLANES-1:0]            pass_q;
	logic                         ovf_out_q;

	// flow control
	logic out_load, s2_free, s1_go, s1_free;

	// accumulate stage logic
	logic [PLANES-1:0] agree;
	logic [PLANES-1:0] acc_next;
	logic [CNT_W-1:0]  cnt_next [PLANES];
	logic [CNT_W-1:0]  total_next;
	logic              ovf_next;
	logic              saturated;

	// threshold stage logic
	logic [PROD_W-1:0] product;
	logic [NEED_W-1:0] need;
	logic [PLANES-1:0] pass;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		unique case (reg_idx)
			bac_pkg::REG_MASK_SHIFT:
				prdata = bac_pkg::DATA_W'(mask_shift_q);
			bac_pkg::REG_THRESHOLD:
				prdata = bac_pkg::DATA_W'(threshold_q);
			default:
				prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_shift_q <= '0;
			threshold_q  <= bac_pkg::ONE_Q16;
		end else if (cfg_wr) begin
			if (reg_idx == bac_pkg::REG_MASK_SHIFT) begin
				mask_shift_q <= pwdata[bac_pkg::SHIFT_W-1:0];
			end
			if (reg_idx == bac_pkg::REG_THRESHOLD) begin
				threshold_q <= pwdata[bac_pkg::THR_W-1:0];
			end
		end
	end

	// ---------------- handshake ----------------
	// a non-last pair never needs the snapshot slot
	assign out_load   = valid_s2 && (!result_valid_q || result_ready);
	assign s2_free    = !valid_s2 || out_load;
	assign s1_go      = valid_s1 && (!last_s1 || s2_free);
	assign s1_free    = !valid_s1 || s1_go;
	assign item_ready = s1_free;

	// ---------------- input register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && item_valid) begin
			word_a_s1 <= word_a;
			word_b_s1 <= word_b;
			last_s1   <= last_element;
		end
	end

	// ---------------- accumulate ----------------
	assign agree     = ~(word_a_s1 ^ word_b_s1);
	assign saturated = (total_q >= CNT_MAX);

	always_comb begin
		acc_next = acc_q & agree;
		if (saturated) begin
			total_next = total_q;
			ovf_next   = 1'b1;
		end else begin
			total_next = total_q + CNT_W'(1);
			ovf_next   = ovf_q;
		end
		for (int m = 0; m < PLANES; m++) begin
			if (saturated) begin
				cnt_next[m] = cnt_q[m];
			end else begin
				cnt_next[m] = cnt_q[m] + CNT_W'(agree[m]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= {PLANES{1'b1}};
			total_q <= '0;
			ovf_q   <= 1'b0;
			for (int m = 0; m < PLANES; m++) begin
				cnt_q[m] <= '0;
			end
		end else begin
			if (s1_go) begin
				if (last_s1) begin
					// neighbourhood done: restart from the shifted start mask
					acc_q   <= bac_pkg::start_mask(mask_shift_q);
					total_q <= '0;
					ovf_q   <= 1'b0;
					for (int m = 0; m < PLANES; m++) begin
						cnt_q[m] <= '0;
					end
				end else begin
					acc_q   <= acc_next;
					total_q <= total_next;
					ovf_q   <= ovf_next;
					for (int m = 0; m < PLANES; m++) begin
						cnt_q[m] <= cnt_next[m];
					end
				end
			end
			// new shift between neighbourhoods reloads the running mask
			if (cfg_wr && reg_idx == bac_pkg::REG_MASK_SHIFT && total_q == '0) begin
				acc_q <= bac_pkg::start_mask(pwdata[bac_pkg::SHIFT_W-1:0]);
			end
		end
	end

	// ---------------- snapshot ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_go && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			acc_s2   <= acc_next;
			total_s2 <= total_next;
			ovf_s2   <= ovf_next;
			for (int m = 0; m < PLANES; m++) begin
				cnt_s2[m] <= cnt_next[m];
			end
		end
	end

	// ---------------- threshold ----------------
	assign product = PROD_W'(threshold_q) * PROD_W'(total_s2);
	assign need    = product[PROD_W-1:bac_pkg::Q_FRAC];

	always_comb begin
		for (int m = 0; m < PLANES; m++) begin
			pass[m] = (NEED_W'(cnt_s2[m]) >= need);
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (!result_valid_q || result_ready) begin
			result_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mask_q    <= acc_s2;
			ones_q    <= bac_pkg::ones_in(acc_s2);
			pass_q    <= pass;
			ovf_out_q <= ovf_s2;
		end
	end

	assign result_valid    = result_valid_q;
	assign all_agree_mask  = mask_q;
	assign agree_bit_total = ones_q;
	assign plane_pass_mask = pass_q;
	assign count_overflow  = ovf_out_q;

endmodule
